[sv/gtrav_pkg.sv]
package gtrav_pkg;

  // Default sizes of the vertex set and the list node store.
  localparam int unsigned DEF_VERTEX_CAP     = 64;
  localparam int unsigned DEF_MAX_LIST_NODES = 256;

  // Fixed field widths.
  localparam int unsigned VTX_W = 6;
  localparam int unsigned NV_W  = 7;
  localparam int unsigned ST_W  = 3;

  // Operation codes; the last one is not used and gives no result.
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_WALK   = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_VISIT     = 3'd0;
  localparam logic [ST_W-1:0] ST_STORED    = 3'd1;
  localparam logic [ST_W-1:0] ST_REJECTED  = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_START = 3'd3;
  localparam logic [ST_W-1:0] ST_CLEARED   = 3'd4;

  // Classified command passed from the front end to the execution unit.
  typedef struct packed {
    logic [1:0]       op;
    logic [VTX_W-1:0] a;
    logic [VTX_W-1:0] b;
    logic             a_ok;
    logic             b_ok;
  } cmd_t;

  // Execution unit states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_HA,
    S_ADD_HB_RD,
    S_ADD_HB,
    S_WALK_HEAD,
    S_STEP,
    S_POP,
    S_NODE,
    S_HEAD,
    S_DONE,
    S_REPLY
  } state_t;

endpackage

[sv/graph_depth_first_traversal_unit.sv]
// Depth-first traversal unit for an undirected graph kept as adjacency lists.
// Input channel (in_valid / in_stall): one word carries op, first_vertex and
// second_vertex. Op 0 adds an edge, op 1 walks from first_vertex, op 2 clears
// the graph; op 3 is dropped. Output channel (out_valid / out_stall): each
// word carries vertex, status and last; last marks the final word of an item.
// Configuration channel (cfg_valid / cfg_ready / cfg_data) writes the vertex
// count; cfg_ready is always high. Write it only while the unit is idle.
// A two-word queue decouples the input side from the execution unit, so
// words are taken while the unit works, until the queue fills.
// A walk proceeds by registered reads of the head, node and stack memories.
// Reset empties all lists, clears the node count and sets 64 vertices; no
// clearing pass is needed. While out_stall is high the result word holds and
// the execution unit waits at its next result.
module graph_depth_first_traversal_unit #(
  parameter int unsigned VERTEX_CAP     = gtrav_pkg::DEF_VERTEX_CAP,
  parameter int unsigned MAX_LIST_NODES = gtrav_pkg::DEF_MAX_LIST_NODES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  op,
  input  logic [gtrav_pkg::VTX_W-1:0] first_vertex,
  input  logic [gtrav_pkg::VTX_W-1:0] second_vertex,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gtrav_pkg::VTX_W-1:0] vertex,
  output logic [gtrav_pkg::ST_W-1:0]  status,
  output logic                        last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [gtrav_pkg::NV_W-1:0]  cfg_data
);
  import gtrav_pkg::*;

  logic [NV_W-1:0] num_vertices;
  logic            q_full;
  logic            front_push;
  logic            q_valid;
  logic            q_pop;
  cmd_t            front_cmd;
  cmd_t            q_data;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;

  // Vertex count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      num_vertices <= NV_W'(64);
    end else if (cfg_valid && cfg_ready) begin
      num_vertices <= cfg_data;
    end
  end

  gtrav_front #(
    .VERTEX_CAP (VERTEX_CAP)
  ) u_front (
    .op            (op),
    .first_vertex  (first_vertex),
    .second_vertex (second_vertex),
    .num_vertices  (num_vertices),
    .in_valid      (in_valid && !q_full),
    .push          (front_push),
    .cmd           (front_cmd)
  );

  gtrav_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (front_push),
    .wr_data  (front_cmd),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_en    (q_pop),
    .rd_data  (q_data)
  );

  gtrav_back #(
    .VERTEX_CAP     (VERTEX_CAP),
    .MAX_LIST_NODES (MAX_LIST_NODES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .num_vertices (num_vertices),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex       (vertex),
    .status       (status),
    .last         (last)
  );

endmodule

[sv/gtrav_front.sv]
module gtrav_front #(
  parameter int unsigned VERTEX_CAP = gtrav_pkg::DEF_VERTEX_CAP
) (
  input  logic [1:0]                 op,
  input  logic [gtrav_pkg::VTX_W-1:0] first_vertex,
  input  logic [gtrav_pkg::VTX_W-1:0] second_vertex,
  input  logic [gtrav_pkg::NV_W-1:0]  num_vertices,
  input  logic                       in_valid,
  output logic                       push,
  output gtrav_pkg::cmd_t            cmd
);
  import gtrav_pkg::*;

  logic [NV_W-1:0] n_active;

  // Vertices in use are limited by the store size.
  assign n_active = (num_vertices > NV_W'(VERTEX_CAP)) ? NV_W'(VERTEX_CAP) : num_vertices;

  // Range-check both vertices ahead of execution.
  always_comb begin
    cmd.op   = op;
    cmd.a    = first_vertex;
    cmd.b    = second_vertex;
    cmd.a_ok = ({1'b0, first_vertex} < n_active);
    cmd.b_ok = ({1'b0, second_vertex} < n_active);
  end

  // The unused operation code is dropped here and gives no result.
  always_comb begin
    case (op)
      OP_ADD, OP_WALK, OP_CLEAR: push = in_valid;
      default:                   push = 1'b0;
    endcase
  end

endmodule

[sv/gtrav_queue.sv]
module gtrav_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  gtrav_pkg::cmd_t wr_data,
  output logic            full,
  output logic            rd_valid,
  input  logic            rd_en,
  output gtrav_pkg::cmd_t rd_data
);
  import gtrav_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full     = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data  = mem[rd_ptr];

  // Two-word queue between front end and execution unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

endmodule

[sv/gtrav_back.sv]
module gtrav_back #(
  parameter int unsigned VERTEX_CAP     = gtrav_pkg::DEF_VERTEX_CAP,
  parameter int unsigned MAX_LIST_NODES = gtrav_pkg::DEF_MAX_LIST_NODES
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [gtrav_pkg::NV_W-1:0]  num_vertices,
  input  logic                        q_valid,
  input  gtrav_pkg::cmd_t             q_data,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [gtrav_pkg::VTX_W-1:0] vertex,
  output logic [gtrav_pkg::ST_W-1:0]  status,
  output logic                        last
);
  import gtrav_pkg::*;

  localparam int unsigned VW = (VERTEX_CAP > 1) ? $clog2(VERTEX_CAP) : 1;
  localparam int unsigned DW = $clog2(VERTEX_CAP + 1);
  localparam int unsigned AW = (MAX_LIST_NODES > 1) ? $clog2(MAX_LIST_NODES) : 1;
  localparam int unsigned NW = $clog2(MAX_LIST_NODES + 1);
  localparam logic [NW-1:0] NULL_NODE = NW'(MAX_LIST_NODES);

  state_t state, state_next;
  cmd_t   cmd;

  // List heads: memory plus one set bit per vertex.
  logic [NW-1:0]           head_mem [VERTEX_CAP];
  logic [NW-1:0]           head_q;
  logic [VW-1:0]           head_ra;
  logic [VERTEX_CAP-1:0]   head_set;
  logic                    head_rd_en;
  logic [VW-1:0]           head_rd_addr;
  logic                    head_we;
  logic [VW-1:0]           head_wa;
  logic [NW-1:0]           head_wd;
  logic [NW-1:0]           head_val;

  // List node store.
  logic [VTX_W-1:0] nb_mem [MAX_LIST_NODES];
  logic [NW-1:0]    lk_mem [MAX_LIST_NODES];
  logic [VTX_W-1:0] node_nb;
  logic [NW-1:0]    node_lk;
  logic             node_rd_en;
  logic [AW-1:0]    node_rd_addr;
  logic             node_we;
  logic [AW-1:0]    node_wa;
  logic [VTX_W-1:0] node_wnb;
  logic [NW-1:0]    node_wlk;

  // Walk stack of saved list positions below the top level.
  logic [NW-1:0] stk_mem [VERTEX_CAP];
  logic [NW-1:0] stk_q;
  logic          stk_rd_en;
  logic [VW-1:0] stk_rd_addr;
  logic          stk_we;
  logic [VW-1:0] stk_wa;

  logic [NW-1:0]           nodes_used;
  logic [DW-1:0]           depth;
  logic [NW-1:0]           top_next;
  logic [VTX_W-1:0]        pending;
  logic [ST_W-1:0]         reply;
  logic [VERTEX_CAP-1:0]   visited;
  logic [NV_W-1:0]         n_active;

  logic             out_free;
  logic             emit;
  logic [VTX_W-1:0] emit_vertex;
  logic [ST_W-1:0]  emit_status;
  logic             emit_last;
  logic             take;
  logic             room;

  assign n_active = (num_vertices > NV_W'(VERTEX_CAP)) ? NV_W'(VERTEX_CAP) : num_vertices;
  assign out_free = !out_valid || !out_stall;
  assign head_val = head_set[head_ra] ? head_q : NULL_NODE;
  assign room     = ({1'b0, nodes_used} + (NW+1)'(2)) <= (NW+1)'(MAX_LIST_NODES);
  assign take     = ({1'b0, node_nb} < n_active) && !visited[node_nb[VW-1:0]]
                    && (depth < DW'(VERTEX_CAP));

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and memory port controls.
  always_comb begin
    state_next   = state;
    q_pop        = 1'b0;
    head_rd_en   = 1'b0;
    head_rd_addr = cmd.a[VW-1:0];
    head_we      = 1'b0;
    head_wa      = cmd.a[VW-1:0];
    head_wd      = nodes_used;
    node_rd_en   = 1'b0;
    node_rd_addr = top_next[AW-1:0];
    node_we      = 1'b0;
    node_wa      = nodes_used[AW-1:0];
    node_wnb     = cmd.b;
    node_wlk     = head_val;
    stk_rd_en    = 1'b0;
    stk_rd_addr  = VW'(depth - DW'(2));
    stk_we       = 1'b0;
    stk_wa       = VW'(depth - DW'(1));
    emit         = 1'b0;
    emit_vertex  = '0;
    emit_status  = reply;
    emit_last    = 1'b1;
    case (state)
      S_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          case (q_data.op)
            OP_ADD: begin
              if (q_data.a_ok && q_data.b_ok && room) begin
                head_rd_en   = 1'b1;
                head_rd_addr = q_data.a[VW-1:0];
                state_next   = S_ADD_HA;
              end else begin
                state_next = S_REPLY;
              end
            end
            OP_WALK: begin
              if (q_data.a_ok) begin
                head_rd_en   = 1'b1;
                head_rd_addr = q_data.a[VW-1:0];
                state_next   = S_WALK_HEAD;
              end else begin
                state_next = S_REPLY;
              end
            end
            default: state_next = S_REPLY;
          endcase
        end
      end
      S_ADD_HA: begin
        node_we    = 1'b1;
        head_we    = 1'b1;
        state_next = S_ADD_HB_RD;
      end
      S_ADD_HB_RD: begin
        head_rd_en   = 1'b1;
        head_rd_addr = cmd.b[VW-1:0];
        state_next   = S_ADD_HB;
      end
      S_ADD_HB: begin
        node_we    = 1'b1;
        node_wa    = AW'(nodes_used + NW'(1));
        node_wnb   = cmd.a;
        head_we    = 1'b1;
        head_wa    = cmd.b[VW-1:0];
        head_wd    = nodes_used + NW'(1);
        state_next = S_REPLY;
      end
      S_WALK_HEAD: state_next = S_STEP;
      S_STEP: begin
        if (depth == '0) begin
          state_next = S_DONE;
        end else if (top_next >= NULL_NODE) begin
          if (depth == DW'(1)) begin
            state_next = S_DONE;
          end else begin
            stk_rd_en  = 1'b1;
            state_next = S_POP;
          end
        end else begin
          node_rd_en = 1'b1;
          state_next = S_NODE;
        end
      end
      S_POP: state_next = S_STEP;
      S_NODE: begin
        if (!take) begin
          state_next = S_STEP;
        end else if (out_free) begin
          emit         = 1'b1;
          emit_vertex  = pending;
          emit_status  = ST_VISIT;
          emit_last    = 1'b0;
          stk_we       = 1'b1;
          head_rd_en   = 1'b1;
          head_rd_addr = node_nb[VW-1:0];
          state_next   = S_HEAD;
        end
      end
      S_HEAD: state_next = S_STEP;
      S_DONE: begin
        if (out_free) begin
          emit        = 1'b1;
          emit_vertex = pending;
          emit_status = ST_VISIT;
          state_next  = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          emit       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Control registers of the execution unit.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_set   <= '0;
      visited    <= '0;
      nodes_used <= '0;
      depth      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (q_valid && q_data.op == OP_CLEAR) begin
            head_set   <= '0;
            nodes_used <= '0;
          end
          // A walk starts with only its start vertex marked.
          if (q_valid && q_data.op == OP_WALK && q_data.a_ok) begin
            visited <= VERTEX_CAP'(1) << q_data.a[VW-1:0];
          end
        end
        S_ADD_HA: head_set[cmd.a[VW-1:0]] <= 1'b1;
        S_ADD_HB: begin
          head_set[cmd.b[VW-1:0]] <= 1'b1;
          nodes_used              <= nodes_used + NW'(2);
        end
        S_WALK_HEAD: depth <= DW'(1);
        S_STEP: begin
          if (depth != '0 && top_next >= NULL_NODE) begin
            depth <= depth - DW'(1);
          end
        end
        S_NODE: begin
          if (take && out_free) begin
            visited[node_nb[VW-1:0]] <= 1'b1;
          end
        end
        S_HEAD: depth <= depth + DW'(1);
        default: ;
      endcase
    end
  end

  // Command, walk position and reply status.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      cmd     <= q_data;
      pending <= q_data.a;
      case (q_data.op)
        OP_ADD:   reply <= ST_REJECTED;
        OP_WALK:  reply <= ST_BAD_START;
        default:  reply <= ST_CLEARED;
      endcase
    end
    if (state == S_ADD_HB) begin
      reply <= ST_STORED;
    end
    if (state == S_WALK_HEAD || state == S_HEAD) begin
      top_next <= head_val;
    end
    if (state == S_POP) begin
      top_next <= stk_q;
    end
    if (state == S_NODE) begin
      top_next <= node_lk;
      if (take && out_free) begin
        pending <= node_nb;
      end
    end
  end

  // List head memory.
  always_ff @(posedge clk) begin
    if (head_we) begin
      head_mem[head_wa] <= head_wd;
    end
    if (head_rd_en) begin
      head_q  <= head_mem[head_rd_addr];
      head_ra <= head_rd_addr;
    end
  end

  // Node store memory.
  always_ff @(posedge clk) begin
    if (node_we) begin
      nb_mem[node_wa] <= node_wnb;
      lk_mem[node_wa] <= node_wlk;
    end
    if (node_rd_en) begin
      node_nb <= nb_mem[node_rd_addr];
      node_lk <= lk_mem[node_rd_addr];
    end
  end

  // Walk stack memory; a push saves the link of the node just taken.
  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wa] <= node_lk;
    end
    if (stk_rd_en) begin
      stk_q <= stk_mem[stk_rd_addr];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      vertex <= emit_vertex;
      status <= emit_status;
      last   <= emit_last;
    end
  end

`ifndef SYNTHESIS
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> depth == '0)
    else $error("walk stack not empty when idle");
  a_nodes_bound: assert property (@(posedge clk) disable iff (rst)
    nodes_used <= NULL_NODE)
    else $error("node store overfilled");
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DW'(VERTEX_CAP))
    else $error("walk stack overflow");
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP && depth == '0) |=> state == S_DONE)
    else $error("empty stack did not end the walk");
`endif

endmodule
